/* src/c8alu_pkg.sv */
`timescale 1ns / 1ps

package c8alu_pkg;

  localparam logic [4:0] OP_ADD   = 5'd0;
  localparam logic [4:0] OP_ADC   = 5'd1;
  localparam logic [4:0] OP_SUB   = 5'd2;
  localparam logic [4:0] OP_SBC   = 5'd3;
  localparam logic [4:0] OP_AND   = 5'd4;
  localparam logic [4:0] OP_XOR   = 5'd5;
  localparam logic [4:0] OP_OR    = 5'd6;
  localparam logic [4:0] OP_CP    = 5'd7;
  localparam logic [4:0] OP_INC   = 5'd8;
  localparam logic [4:0] OP_DEC   = 5'd9;
  localparam logic [4:0] OP_RLC   = 5'd10;
  localparam logic [4:0] OP_RRC   = 5'd11;
  localparam logic [4:0] OP_RL    = 5'd12;
  localparam logic [4:0] OP_RR    = 5'd13;
  localparam logic [4:0] OP_SLA   = 5'd14;
  localparam logic [4:0] OP_SRA   = 5'd15;
  localparam logic [4:0] OP_SWAP  = 5'd16;
  localparam logic [4:0] OP_SRL   = 5'd17;
  localparam logic [4:0] OP_BIT   = 5'd18;
  localparam logic [4:0] OP_RES   = 5'd19;
  localparam logic [4:0] OP_SET   = 5'd20;
  localparam logic [4:0] OP_RLCA  = 5'd21;
  localparam logic [4:0] OP_RRCA  = 5'd22;
  localparam logic [4:0] OP_RLA   = 5'd23;
  localparam logic [4:0] OP_RRA   = 5'd24;
  localparam logic [4:0] OP_DAA   = 5'd25;
  localparam logic [4:0] OP_CPL   = 5'd26;
  localparam logic [4:0] OP_SCF   = 5'd27;
  localparam logic [4:0] OP_CCF   = 5'd28;
  localparam logic [4:0] OP_ADD16 = 5'd29;
  localparam logic [4:0] OP_ADDSP = 5'd30;

  // flag bit positions
  localparam int FLAG_Z = 3;
  localparam int FLAG_N = 2;
  localparam int FLAG_H = 1;
  localparam int FLAG_C = 0;

  typedef struct packed {
    logic [4:0]  opcode;
    logic [15:0] first_operand;
    logic [15:0] second_operand;
    logic [2:0]  bit_index;
    logic [3:0]  flags_in;
  } item_t;

  typedef struct packed {
    logic [15:0] result_value;
    logic [3:0]  flags_out;
  } res_t;

endpackage

/* src/c8alu_core.sv */
`timescale 1ns / 1ps

module c8alu_core (
  input  c8alu_pkg::item_t item,
  output c8alu_pkg::res_t  res
);

  localparam logic [2:0] SH_RLC  = 3'd0;
  localparam logic [2:0] SH_RRC  = 3'd1;
  localparam logic [2:0] SH_RL   = 3'd2;
  localparam logic [2:0] SH_RR   = 3'd3;
  localparam logic [2:0] SH_SLA  = 3'd4;
  localparam logic [2:0] SH_SRA  = 3'd5;
  localparam logic [2:0] SH_SWAP = 3'd6;
  localparam logic [2:0] SH_SRL  = 3'd7;

  logic [7:0]  a;
  logic [7:0]  b;
  logic        cy;
  logic        nf;
  logic        cin_add;
  logic        cin_sub;
  logic [8:0]  add8;
  logic [4:0]  add4;
  logic [8:0]  sub8;
  logic [4:0]  sub4;
  logic [7:0]  inc8;
  logic [7:0]  dec8;
  logic [2:0]  sh_k;
  logic [4:0]  sh_off;
  logic [7:0]  sh_r;
  logic        sh_c;
  logic [7:0]  bit_mask;
  logic [7:0]  daa_corr;
  logic        daa_c;
  logic [7:0]  daa_r;
  logic [16:0] add16;
  logic [12:0] add12;
  logic [15:0] sp_ext;
  logic [15:0] sp_sum;
  logic [4:0]  sp4;
  logic [8:0]  sp8;
  logic [7:0]  r8;

  assign a  = item.first_operand[7:0];
  assign b  = item.second_operand[7:0];
  assign cy = item.flags_in[c8alu_pkg::FLAG_C];
  assign nf = item.flags_in[c8alu_pkg::FLAG_N];

  assign cin_add = (item.opcode == c8alu_pkg::OP_ADC) && cy;
  assign cin_sub = (item.opcode == c8alu_pkg::OP_SBC) && cy;

  assign add8 = {1'b0, a} + {1'b0, b} + {8'd0, cin_add};
  assign add4 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin_add};
  // bit 8 / bit 4 of the difference is the borrow
  assign sub8 = {1'b0, a} - {1'b0, b} - {8'd0, cin_sub};
  assign sub4 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin_sub};
  assign inc8 = a + 8'd1;
  assign dec8 = a - 8'd1;

  assign sh_off = (item.opcode >= c8alu_pkg::OP_RLCA) ? (item.opcode - c8alu_pkg::OP_RLCA)
                                                       : (item.opcode - c8alu_pkg::OP_RLC);
  assign sh_k   = sh_off[2:0];

  always_comb begin
    sh_r = a;
    sh_c = 1'b0;
    unique case (sh_k)
      SH_RLC:  begin sh_c = a[7]; sh_r = {a[6:0], a[7]}; end
      SH_RRC:  begin sh_c = a[0]; sh_r = {a[0], a[7:1]}; end
      SH_RL:   begin sh_c = a[7]; sh_r = {a[6:0], cy}; end
      SH_RR:   begin sh_c = a[0]; sh_r = {cy, a[7:1]}; end
      SH_SLA:  begin sh_c = a[7]; sh_r = {a[6:0], 1'b0}; end
      SH_SRA:  begin sh_c = a[0]; sh_r = {a[7], a[7:1]}; end
      SH_SWAP: begin sh_c = 1'b0; sh_r = {a[3:0], a[7:4]}; end
      SH_SRL:  begin sh_c = a[0]; sh_r = {1'b0, a[7:1]}; end
      default: begin sh_c = 1'b0; sh_r = a; end
    endcase
  end

  assign bit_mask = 8'd1 << item.bit_index;

  always_comb begin
    daa_corr = 8'h00;
    daa_c    = cy;
    if (item.flags_in[c8alu_pkg::FLAG_H] || (!nf && (a[3:0] > 4'h9))) begin
      daa_corr[3:0] = 4'h6;
    end
    if (cy || (!nf && (a > 8'h99))) begin
      daa_corr[7:4] = 4'h6;
      daa_c         = 1'b1;
    end
  end
  assign daa_r = nf ? (a - daa_corr) : (a + daa_corr);

  assign add16  = {1'b0, item.first_operand} + {1'b0, item.second_operand};
  assign add12  = {1'b0, item.first_operand[11:0]} + {1'b0, item.second_operand[11:0]};
  assign sp_ext = {{8{b[7]}}, b};
  assign sp_sum = item.first_operand + sp_ext;
  assign sp4    = {1'b0, item.first_operand[3:0]} + {1'b0, b[3:0]};
  assign sp8    = {1'b0, item.first_operand[7:0]} + {1'b0, b};

  always_comb begin
    r8                = a;
    res.result_value  = {8'd0, a};
    res.flags_out     = item.flags_in;
    unique case (item.opcode) inside
      c8alu_pkg::OP_ADD, c8alu_pkg::OP_ADC: begin
        r8            = add8[7:0];
        res.flags_out = {r8 == 8'd0, 1'b0, add4[4], add8[8]};
      end
      c8alu_pkg::OP_SUB, c8alu_pkg::OP_SBC, c8alu_pkg::OP_CP: begin
        r8 = (item.opcode == c8alu_pkg::OP_CP) ? a : sub8[7:0];
        res.flags_out = {sub8[7:0] == 8'd0, 1'b1, sub4[4], sub8[8]};
      end
      c8alu_pkg::OP_AND: begin
        r8            = a & b;
        res.flags_out = {r8 == 8'd0, 1'b0, 1'b1, 1'b0};
      end
      c8alu_pkg::OP_XOR: begin
        r8            = a ^ b;
        res.flags_out = {r8 == 8'd0, 3'b000};
      end
      c8alu_pkg::OP_OR: begin
        r8            = a | b;
        res.flags_out = {r8 == 8'd0, 3'b000};
      end
      c8alu_pkg::OP_INC: begin
        r8            = inc8;
        res.flags_out = {r8 == 8'd0, 1'b0, r8[3:0] == 4'h0, cy};
      end
      c8alu_pkg::OP_DEC: begin
        r8            = dec8;
        res.flags_out = {r8 == 8'd0, 1'b1, r8[3:0] == 4'hF, cy};
      end
      [c8alu_pkg::OP_RLC : c8alu_pkg::OP_SRL]: begin
        r8            = sh_r;
        res.flags_out = {r8 == 8'd0, 2'b00, sh_c};
      end
      [c8alu_pkg::OP_RLCA : c8alu_pkg::OP_RRA]: begin
        r8            = sh_r;
        res.flags_out = {3'b000, sh_c};
      end
      c8alu_pkg::OP_BIT: begin
        res.flags_out = {(a & bit_mask) == 8'd0, 1'b0, 1'b1, cy};
      end
      c8alu_pkg::OP_RES: r8 = a & ~bit_mask;
      c8alu_pkg::OP_SET: r8 = a | bit_mask;
      c8alu_pkg::OP_DAA: begin
        r8            = daa_r;
        res.flags_out = {r8 == 8'd0, nf, 1'b0, daa_c};
      end
      c8alu_pkg::OP_CPL: begin
        r8            = ~a;
        res.flags_out = {item.flags_in[c8alu_pkg::FLAG_Z], 2'b11, cy};
      end
      c8alu_pkg::OP_SCF: res.flags_out = {item.flags_in[c8alu_pkg::FLAG_Z], 3'b001};
      c8alu_pkg::OP_CCF: res.flags_out = {item.flags_in[c8alu_pkg::FLAG_Z], 2'b00, ~cy};
      default: ;
    endcase

    unique case (item.opcode) inside
      c8alu_pkg::OP_ADD16: begin
        res.result_value = add16[15:0];
        res.flags_out    = {item.flags_in[c8alu_pkg::FLAG_Z], 1'b0, add12[12], add16[16]};
      end
      c8alu_pkg::OP_ADDSP: begin
        res.result_value = sp_sum;
        res.flags_out    = {2'b00, sp4[4], sp8[8]};
      end
      [c8alu_pkg::OP_ADD : c8alu_pkg::OP_CCF]: res.result_value = {8'd0, r8};
      default: res.result_value = item.first_operand;
    endcase
  end

endmodule

/* src/cpu8_alu_with_flags_top.sv */
`timescale 1ns / 1ps

// 8-bit processor ALU with Z/N/H/C flags. One word in gives one word out:
// the result and the new flags. The input word is registered, the ALU is a
// single combinational pass, and the result is registered, so a word can be
// accepted every clock while the output side is not stalled. Both registers
// hold under backpressure; in_ready is high outside reset while the input
// register is empty or the result register can take its word.
module cpu8_alu_with_flags_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [4:0]  opcode,
  input  logic [15:0] first_operand,
  input  logic [15:0] second_operand,
  input  logic [2:0]  bit_index,
  input  logic [3:0]  flags_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] result_value,
  output logic [3:0]  flags_out
);

  c8alu_pkg::item_t in_reg;
  logic             in_reg_valid;
  c8alu_pkg::res_t  res_comb;
  c8alu_pkg::res_t  res_reg;
  logic             res_reg_valid;
  logic             res_free;
  logic             in_free;

  assign res_free = !res_reg_valid || out_ready;
  assign in_free  = !in_reg_valid || res_free;
  assign in_ready = !rst && in_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_free) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_reg <= '{opcode, first_operand, second_operand, bit_index, flags_in};
    end
  end

  c8alu_core u_core (
    .item (in_reg),
    .res  (res_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_reg_valid <= 1'b0;
    end else if (res_free) begin
      res_reg_valid <= in_reg_valid;
    end
  end

  // advance the result word only when the output slot is free
  always_ff @(posedge clk) begin
    if (res_free && in_reg_valid) begin
      res_reg <= res_comb;
    end
  end

  assign out_valid    = res_reg_valid;
  assign result_value = res_reg.result_value;
  assign flags_out    = res_reg.flags_out;

endmodule

/* src/c8alu_checker.sv */
`timescale 1ns / 1ps

module c8alu_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] result_value,
  input logic [3:0]  flags_out
);

  // a stalled result word stays up
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(result_value) && $stable(flags_out))
    else $error("result word changed while stalled");

  // after an accepted word the output must show a valid result word
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> ##2 out_valid)
    else $error("accepted word did not reach the output");

  // no result word appears out of an empty pipeline
  assert property (@(posedge clk) disable iff (rst)
    !$past(out_valid) && !$past(in_valid && in_ready, 2) |-> !out_valid)
    else $error("result word without an accepted input");

endmodule

bind cpu8_alu_with_flags_top c8alu_checker u_c8alu_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .result_value (result_value),
  .flags_out    (flags_out)
);

/* tb/cpu8_alu_with_flags_top_test.sv */
`timescale 1ns / 1ps

module cpu8_alu_with_flags_top_test;

  localparam logic [4:0] OP_NONE = 5'd31;  // unassigned opcode, passes the word through
  localparam int MAX_REPORTS  = 10;
  localparam int RANDOM_WORDS = 1500;
  localparam int HOLD_CYCLES  = 80;

  typedef struct packed {
    logic [4:0]      opcode;
    c8alu_pkg::res_t want;
  } alu_expect_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [4:0]  opcode = '0;
  logic [15:0] first_operand = '0;
  logic [15:0] second_operand = '0;
  logic [2:0]  bit_index = '0;
  logic [3:0]  flags_in = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] result_value;
  logic [3:0]  flags_out;

  c8alu_pkg::item_t words_to_send[$];
  alu_expect_t      expected_results[$];
  logic [7:0]  byte_corner [8] = '{8'h00, 8'hFF, 8'h0F, 8'h10, 8'h7F, 8'h80, 8'h99, 8'h9A};

  int   n_sent = 0;
  int   n_checked = 0;
  int   n_errors = 0;
  int   n_stalled = 0;
  int   send_gap = 0;
  int   recv_stall = 0;
  bit   send_burst = 1'b0;
  bit   recv_burst = 1'b0;
  logic in_taken = 1'b0;
  logic long_hold = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cpu8_alu_with_flags_top u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .first_operand  (first_operand),
    .second_operand (second_operand),
    .bit_index      (bit_index),
    .flags_in       (flags_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result_value   (result_value),
    .flags_out      (flags_out)
  );

  function automatic c8alu_pkg::res_t alu_predict(c8alu_pkg::item_t w);
    logic [7:0]  a, b, r8, corr;
    logic [8:0]  sum9;
    logic [4:0]  nib;
    logic [12:0] sum13;
    logic [16:0] sum17;
    logic        cy, cin, nc, sub, half, carry;
    c8alu_pkg::res_t res;
    a    = w.first_operand[7:0];
    b    = w.second_operand[7:0];
    cy   = w.flags_in[c8alu_pkg::FLAG_C];
    sub  = w.flags_in[c8alu_pkg::FLAG_N];
    half = w.flags_in[c8alu_pkg::FLAG_H];
    res.result_value = {8'h00, a};
    res.flags_out    = w.flags_in;
    case (w.opcode)
      c8alu_pkg::OP_ADD, c8alu_pkg::OP_ADC: begin
        cin  = (w.opcode == c8alu_pkg::OP_ADC) ? cy : 1'b0;
        sum9 = {1'b0, a} + {1'b0, b} + {8'h00, cin};
        nib  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, cin};
        res.result_value = {8'h00, sum9[7:0]};
        res.flags_out    = {sum9[7:0] == 8'h00, 1'b0, nib[4], sum9[8]};
      end
      c8alu_pkg::OP_SUB, c8alu_pkg::OP_SBC, c8alu_pkg::OP_CP: begin
        cin = (w.opcode == c8alu_pkg::OP_SBC) ? cy : 1'b0;
        r8  = a - b - {7'h00, cin};
        res.flags_out = {r8 == 8'h00, 1'b1,
                         {1'b0, a[3:0]} < {1'b0, b[3:0]} + {4'h0, cin},
                         {1'b0, a} < {1'b0, b} + {8'h00, cin}};
        // compare keeps the accumulator
        if (w.opcode != c8alu_pkg::OP_CP) res.result_value = {8'h00, r8};
      end
      c8alu_pkg::OP_AND: begin
        r8 = a & b;
        res.result_value = {8'h00, r8};
        res.flags_out    = {r8 == 8'h00, 1'b0, 1'b1, 1'b0};
      end
      c8alu_pkg::OP_XOR, c8alu_pkg::OP_OR: begin
        r8 = (w.opcode == c8alu_pkg::OP_XOR) ? (a ^ b) : (a | b);
        res.result_value = {8'h00, r8};
        res.flags_out    = {r8 == 8'h00, 3'b000};
      end
      c8alu_pkg::OP_INC: begin
        r8 = a + 8'h01;
        res.result_value = {8'h00, r8};
        res.flags_out    = {r8 == 8'h00, 1'b0, r8[3:0] == 4'h0, cy};
      end
      c8alu_pkg::OP_DEC: begin
        r8 = a - 8'h01;
        res.result_value = {8'h00, r8};
        res.flags_out    = {r8 == 8'h00, 1'b1, r8[3:0] == 4'hF, cy};
      end
      c8alu_pkg::OP_RLC, c8alu_pkg::OP_RRC, c8alu_pkg::OP_RL, c8alu_pkg::OP_RR,
      c8alu_pkg::OP_SLA, c8alu_pkg::OP_SRA, c8alu_pkg::OP_SWAP, c8alu_pkg::OP_SRL,
      c8alu_pkg::OP_RLCA, c8alu_pkg::OP_RRCA, c8alu_pkg::OP_RLA, c8alu_pkg::OP_RRA: begin
        case (w.opcode)
          c8alu_pkg::OP_RLC, c8alu_pkg::OP_RLCA: begin nc = a[7]; r8 = {a[6:0], a[7]}; end
          c8alu_pkg::OP_RRC, c8alu_pkg::OP_RRCA: begin nc = a[0]; r8 = {a[0], a[7:1]}; end
          c8alu_pkg::OP_RL, c8alu_pkg::OP_RLA:   begin nc = a[7]; r8 = {a[6:0], cy}; end
          c8alu_pkg::OP_RR, c8alu_pkg::OP_RRA:   begin nc = a[0]; r8 = {cy, a[7:1]}; end
          c8alu_pkg::OP_SLA:  begin nc = a[7]; r8 = {a[6:0], 1'b0}; end
          c8alu_pkg::OP_SRA:  begin nc = a[0]; r8 = {a[7], a[7:1]}; end
          c8alu_pkg::OP_SWAP: begin nc = 1'b0; r8 = {a[3:0], a[7:4]}; end
          default:            begin nc = a[0]; r8 = {1'b0, a[7:1]}; end
        endcase
        res.result_value = {8'h00, r8};
        // accumulator rotates always clear Z
        res.flags_out = {(w.opcode >= c8alu_pkg::OP_RLCA) ? 1'b0 : (r8 == 8'h00),
                         2'b00, nc};
      end
      c8alu_pkg::OP_BIT: res.flags_out = {~a[w.bit_index], 1'b0, 1'b1, cy};
      c8alu_pkg::OP_RES: res.result_value = {8'h00, a & ~(8'h01 << w.bit_index)};
      c8alu_pkg::OP_SET: res.result_value = {8'h00, a | (8'h01 << w.bit_index)};
      c8alu_pkg::OP_DAA: begin
        corr  = 8'h00;
        carry = cy;
        if (half || (!sub && a[3:0] > 4'd9)) corr = corr | 8'h06;
        if (cy || (!sub && a > 8'h99)) begin
          corr  = corr | 8'h60;
          carry = 1'b1;
        end
        r8 = sub ? (a - corr) : (a + corr);
        res.result_value = {8'h00, r8};
        res.flags_out    = {r8 == 8'h00, sub, 1'b0, carry};
      end
      c8alu_pkg::OP_CPL: begin
        res.result_value = {8'h00, ~a};
        res.flags_out    = {w.flags_in[c8alu_pkg::FLAG_Z], 1'b1, 1'b1, cy};
      end
      c8alu_pkg::OP_SCF: res.flags_out = {w.flags_in[c8alu_pkg::FLAG_Z], 2'b00, 1'b1};
      c8alu_pkg::OP_CCF: res.flags_out = {w.flags_in[c8alu_pkg::FLAG_Z], 2'b00, ~cy};
      c8alu_pkg::OP_ADD16: begin
        sum17 = {1'b0, w.first_operand} + {1'b0, w.second_operand};
        sum13 = {1'b0, w.first_operand[11:0]} + {1'b0, w.second_operand[11:0]};
        res.result_value = sum17[15:0];
        res.flags_out    = {w.flags_in[c8alu_pkg::FLAG_Z], 1'b0, sum13[12], sum17[16]};
      end
      c8alu_pkg::OP_ADDSP: begin
        // flags come from the unsigned low-byte add, the value from the signed one
        nib  = {1'b0, w.first_operand[3:0]} + {1'b0, b[3:0]};
        sum9 = {1'b0, w.first_operand[7:0]} + {1'b0, b};
        res.result_value = w.first_operand + {{8{b[7]}}, b};
        res.flags_out    = {2'b00, nib[4], sum9[8]};
      end
      default: res.result_value = w.first_operand;
    endcase
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] pick_operand();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3:    return {8'($urandom), byte_corner[$urandom_range(0, 7)]};
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_word(input logic [4:0] op, input logic [15:0] x,
                            input logic [15:0] y, input logic [2:0] bi,
                            input logic [3:0] fl);
    c8alu_pkg::item_t w;
    w.opcode         = op;
    w.first_operand  = x;
    w.second_operand = y;
    w.bit_index      = bi;
    w.flags_in       = fl;
    words_to_send.push_back(w);
  endtask

  // sender: new word at the falling edge once the previous one was taken
  always @(negedge clk) begin : sender
    c8alu_pkg::item_t w;
    if (!rst) begin
      if (in_valid && !in_taken) begin
        // hold the word until the block takes it
      end else if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap--;
      end else if (words_to_send.size() != 0) begin
        w = words_to_send.pop_front();
        {opcode, first_operand, second_operand, bit_index, flags_in} <= w;
        in_valid <= 1'b1;
        if ($urandom_range(0, 99) == 0) send_burst = !send_burst;
        send_gap = send_burst ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : receiver
    if (!rst) begin
      if (long_hold) begin
        out_ready <= 1'b0;
      end else if (recv_stall > 0) begin
        out_ready <= 1'b0;
        recv_stall--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 149) == 0) recv_burst = !recv_burst;
        if (!recv_burst && $urandom_range(0, 3) == 0) recv_stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : monitor
    alu_expect_t e;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && !in_ready) n_stalled++;
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          if (n_errors < MAX_REPORTS)
            $display("%0t: unexpected result value %h flags %b", $time,
                     result_value, flags_out);
          n_errors++;
        end else begin
          e = expected_results.pop_front();
          n_checked++;
          if (result_value !== e.want.result_value || flags_out !== e.want.flags_out) begin
            if (n_errors < MAX_REPORTS)
              $display("%0t: opcode %0d expected value %h flags %b, got value %h flags %b",
                       $time, e.opcode, e.want.result_value, e.want.flags_out,
                       result_value, flags_out);
            n_errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        e.opcode = opcode;
        e.want   = alu_predict({opcode, first_operand, second_operand, bit_index, flags_in});
        expected_results.push_back(e);
        n_sent++;
      end
    end
  end

  // stall the output for a long stretch so the pipeline fills and drops in_ready
  initial begin : hold_off
    while (n_checked < 200) @(posedge clk);
    @(negedge clk);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    long_hold <= 1'b0;
  end

  initial begin : stimulus
    c8alu_pkg::item_t w;
    // one word per opcode, operands and flags swept across their extremes
    for (int k = int'(c8alu_pkg::OP_ADD); k <= int'(OP_NONE); k++)
      queue_word(5'(k), (k % 2 != 0) ? 16'hFFFF : 16'h0000,
                 (k % 3 == 0) ? 16'hFFFF : 16'h0001, 3'(k), 4'(k));
    queue_word(c8alu_pkg::OP_ADD, 16'h000F, 16'h0001, 3'd0, 4'h0);    // half carry only
    queue_word(c8alu_pkg::OP_CP, 16'h0042, 16'h0042, 3'd0, 4'h0);     // equal, accumulator kept
    queue_word(c8alu_pkg::OP_DAA, 16'h009A, 16'h0000, 3'd0, 4'h0);    // both corrections after add
    queue_word(c8alu_pkg::OP_DAA, 16'h0000, 16'h0000, 3'd0, 4'h7);    // after subtract, H and C set
    queue_word(c8alu_pkg::OP_ADD16, 16'h0FFF, 16'h0001, 3'd0, 4'h8);  // carry out of bit 11, Z kept
    queue_word(c8alu_pkg::OP_ADDSP, 16'hFFF8, 16'h0088, 3'd0, 4'hF);  // negative offset
    queue_word(c8alu_pkg::OP_BIT, 16'h0080, 16'h0000, 3'd6, 4'h1);    // tested bit clear
    queue_word(c8alu_pkg::OP_RLA, 16'h0080, 16'h0000, 3'd0, 4'h0);    // zero result, Z still clear
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      w.opcode = ($urandom_range(0, 49) == 0)
                 ? OP_NONE : 5'($urandom_range(0, int'(c8alu_pkg::OP_ADDSP)));
      w.first_operand  = pick_operand();
      w.second_operand = pick_operand();
      w.bit_index      = 3'($urandom);
      w.flags_in       = 4'($urandom);
      words_to_send.push_back(w);
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (words_to_send.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Covered all 32 opcodes: %0d words sent, %0d results checked, %0d errors",
             n_sent, n_checked, n_errors);
    $display("Input held off by backpressure for %0d cycles", n_stalled);
    if (n_errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
